[sv/sopc_pkg.sv]
// Shared types, character codes and helpers for the sum-of-products syntax checker.
package sopc_pkg;

    // Item kinds on the input channel.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_END  = 1'b1;

    // Characters with a meaning in the expression grammar.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_APOS  = 8'h27;

    // One input transaction.
    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic valid_res;
    } t_out_item;

    // Single-bit parser flags; the depth counter travels separately.
    typedef struct packed {
        logic after_letter;
        logic after_close;
        logic after_operator;
        logic after_negation;
        logic ends_in_operator;
        logic group_open;
        logic sum_in_group;
        logic need_plus_or_negation;
        logic failed;
    } t_flags;

    localparam t_flags FLAGS_RESET = '0;

    // True for A-Z and a-z.
    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

endpackage

[sv/sopc_stream_if.sv]
// Valid/ready stream interface with a typed payload.
interface sopc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[sv/sum_of_products_syntax_checker_core.sv]
// Top level of the sum-of-products syntax checker.
//
//  Channel  Direction  Payload           Transaction
//  i_in     sink       kind, ch          one character or an end marker
//  o_out    source     valid_res         one verdict per end marker
//
// Each transaction is registered in the input register and then updates the parser
// state; an end marker's verdict is then registered in the result register, where it
// stays until taken. One character is taken per cycle unless an end marker is stalled.
// Reset clears the parser state and both valid bits. A stalled result holds the end
// marker behind it in the input register, and with it all later input.
module sum_of_products_syntax_checker_core #(
    parameter int DEPTH_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sopc_stream_if.sink        i_in,
    sopc_stream_if.source      o_out
);

    logic                  r_in_valid;
    sopc_pkg::t_in_item    r_in;
    sopc_pkg::t_flags      r_flags;
    logic [DEPTH_BITS-1:0] r_depth;
    logic                  r_out_valid;
    sopc_pkg::t_out_item   r_out;

    sopc_pkg::t_flags      n_flags;
    logic [DEPTH_BITS-1:0] n_depth;
    logic                  step_ok;
    logic                  out_free;
    logic                  stage_retire;
    logic                  in_take;

    // Handshake: the input stage empties unless an end marker meets a full result slot that is not taken.
    assign out_free     = !r_out_valid || o_out.ready;
    assign stage_retire = r_in_valid && ((r_in.kind == sopc_pkg::KIND_CHAR) || out_free);
    assign i_in.ready   = !r_in_valid || stage_retire;
    assign in_take      = i_in.valid && i_in.ready;

    assign o_out.valid  = r_out_valid;
    assign o_out.data   = r_out;

    sopc_step #(
        .DEPTH_BITS (DEPTH_BITS)
    ) u_step (
        .i_item  (r_in),
        .i_flags (r_flags),
        .i_depth (r_depth),
        .o_flags (n_flags),
        .o_depth (n_depth),
        .o_ok    (step_ok)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= in_take;
        end
        if (in_take) begin
            r_in <= i_in.data;
        end
    end

    // Parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= sopc_pkg::FLAGS_RESET;
            r_depth <= '0;
        end else if (stage_retire) begin
            r_flags <= n_flags;
            r_depth <= n_depth;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_retire && (r_in.kind == sopc_pkg::KIND_END)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (stage_retire && (r_in.kind == sopc_pkg::KIND_END)) begin
            r_out.valid_res <= step_ok;
        end
    end

endmodule

[sv/sopc_step.sv]
// Next-state logic of the parser for one input transaction.
module sopc_step #(
    parameter int DEPTH_BITS = 8
) (
    input  sopc_pkg::t_in_item        i_item,
    input  sopc_pkg::t_flags          i_flags,
    input  logic [DEPTH_BITS-1:0]     i_depth,
    output sopc_pkg::t_flags          o_flags,
    output logic [DEPTH_BITS-1:0]     o_depth,
    output logic                      o_ok
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    // Verdict for an end transaction.
    assign o_ok = !i_flags.failed && (i_depth == '0) && !i_flags.ends_in_operator &&
                  !i_flags.need_plus_or_negation;

    // Character handling; an end transaction returns everything to reset.
    always_comb begin
        logic       blocked;
        logic [7:0] c;
        blocked = 1'b0;
        c       = i_item.ch;
        o_flags = i_flags;
        o_depth = i_depth;
        if (i_item.kind == sopc_pkg::KIND_END) begin
            o_flags = sopc_pkg::FLAGS_RESET;
            o_depth = '0;
        end else if (!i_flags.failed && (c != sopc_pkg::CH_SPACE)) begin
            // A closed group that held a sum must be followed by + or negation.
            if (i_flags.need_plus_or_negation) begin
                o_flags.need_plus_or_negation = 1'b0;
                if ((c != sopc_pkg::CH_PLUS) && (c != sopc_pkg::CH_APOS)) begin
                    o_flags.failed = 1'b1;
                    blocked        = 1'b1;
                end
            end
            if (!blocked) begin
                if (c == sopc_pkg::CH_OPEN) begin
                    o_flags.group_open       = 1'b1;
                    o_flags.sum_in_group     = 1'b0;
                    o_flags.ends_in_operator = 1'b0;
                    o_flags.after_close      = 1'b0;
                    if (i_depth == DEPTH_MAX) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        o_depth = i_depth + 1'b1;
                    end
                end else if (c == sopc_pkg::CH_CLOSE) begin
                    if (i_flags.after_operator || !i_flags.group_open) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        if (i_flags.sum_in_group) begin
                            o_flags.need_plus_or_negation = 1'b1;
                        end
                        o_flags.group_open  = 1'b0;
                        o_flags.after_close = 1'b1;
                        if (i_depth != '0) begin
                            o_depth = i_depth - 1'b1;
                        end
                    end
                end else if ((c == sopc_pkg::CH_PLUS) || (c == sopc_pkg::CH_STAR)) begin
                    if (!i_flags.after_letter && !i_flags.after_negation) begin
                        o_flags.failed = 1'b1;
                    end else if ((c == sopc_pkg::CH_STAR) && i_flags.after_operator) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        if ((c == sopc_pkg::CH_PLUS) && i_flags.group_open) begin
                            o_flags.sum_in_group = 1'b1;
                        end
                        o_flags.after_operator   = 1'b1;
                        o_flags.after_letter     = 1'b0;
                        o_flags.after_negation   = 1'b0;
                        o_flags.ends_in_operator = 1'b1;
                        o_flags.after_close      = 1'b0;
                    end
                end else if (sopc_pkg::is_letter(c)) begin
                    o_flags.after_letter     = 1'b1;
                    o_flags.after_operator   = 1'b0;
                    o_flags.after_negation   = 1'b0;
                    o_flags.ends_in_operator = 1'b0;
                    o_flags.after_close      = 1'b0;
                end else if (c == sopc_pkg::CH_APOS) begin
                    if (!i_flags.after_letter && !i_flags.after_negation &&
                        !i_flags.after_close) begin
                        o_flags.failed = 1'b1;
                    end else begin
                        o_flags.after_letter     = 1'b0;
                        o_flags.after_negation   = 1'b1;
                        o_flags.after_operator   = 1'b0;
                        o_flags.ends_in_operator = 1'b0;
                        o_flags.after_close      = 1'b0;
                    end
                end else begin
                    o_flags.failed = 1'b1;
                end
            end
        end
    end

endmodule
